@@ rtl/core/chn_pkg.sv @@
// ============================================================================
// chn_pkg: shared types and constants for the coordinate hash noise block
// Item and result structs, action codes and the per-channel round constants.
// ============================================================================
package chn_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        ACT_ONE   = 2'd0,
        ACT_TWO   = 2'd1,
        ACT_THREE = 2'd2,
        ACT_UNIT  = 2'd3
    } action_t;

    typedef struct packed {
        action_t action;
        word_t   coord_a;
        word_t   coord_b;
        word_t   coord_c;
    } in_item_t;

    typedef struct packed {
        logic [21:0] hash_value;
        logic [23:0] fraction;
    } out_item_t;

    typedef struct packed {
        logic            unit_mode;
        word_t [2:0]     seed;
    } seed_item_t;

    localparam int NUM_CH = 3;

    localparam logic [20:0] MODULUS [NUM_CH] = '{21'd1393137, 21'd1393148, 21'd1393151};
    localparam logic [7:0]  MOD_WEIGHT [NUM_CH] = '{8'd103, 8'd161, 8'd109};
    localparam logic [7:0]  AND_WEIGHT [NUM_CH] = '{8'd149, 8'd123, 8'd157};
    localparam logic [20:0] RESULT_MASK [NUM_CH] = '{21'd1395253, 21'd1395314, 21'd1395329};

    // floor(2^32 / M); the quotient estimate is then low by at most one
    localparam logic [11:0] MOD_RECIP [NUM_CH] = '{
        12'((64'd1 << 32) / 64'd1393137),
        12'((64'd1 << 32) / 64'd1393148),
        12'((64'd1 << 32) / 64'd1393151)
    };

    localparam logic [18:0] FRAC_DIV [NUM_CH] = '{19'd390253, 19'd390299, 19'd390313};

    localparam logic [21:0] HASH_MAX = 22'd4185896;

endpackage

@@ rtl/core/coordinate_hash_noise.sv @@
// ============================================================================
// coordinate_hash_noise: stateless coordinate hash
// Forms three seeds from the item's action and coordinates, runs one mixing
// round per channel; returns the channel sum and a unit-mode scaled fraction.
//
// Input channel item_valid/item_stall/item: a transfer happens on a rising
// edge with item_valid high and item_stall low. Output channel result_valid/
// result_stall/result behaves the same way, one result per item, in order.
// Path from input transfer to result_valid: the input stage, the seed queue
// store, six pipeline stages of the mixing round, then the output
// register. Throughput is one item per cycle while the receiver does not
// stall, set by the fully pipelined back end.
// When the receiver stalls, the whole back pipeline holds, the seed queue
// (QUEUE_DEPTH entries) fills, and item_stall rises once it is full.
// Reset clears all valid flags, the queue pointers and count; no other state.
// ============================================================================
module coordinate_hash_noise #(
    parameter int FRACTION_BITS = 24,
    parameter int QUEUE_DEPTH   = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  chn_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_stall,
    output chn_pkg::out_item_t result
);
    import chn_pkg::*;

    logic       seed_valid;
    seed_item_t seed;
    logic       queue_full;
    logic       head_valid;
    seed_item_t head;
    logic       pop;

    chn_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .queue_full (queue_full),
        .seed_valid (seed_valid),
        .seed       (seed)
    );

    chn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (seed_valid),
        .wr_data  (seed),
        .full     (queue_full),
        .pop      (pop),
        .rd_valid (head_valid),
        .rd_data  (head)
    );

    chn_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ rtl/core/chn_front.sv @@
// ============================================================================
// chn_front: input stage
// Takes an item, decodes the action and registers the three channel seeds.
// ============================================================================
module chn_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  chn_pkg::in_item_t item,
    input  logic              queue_full,
    output logic              seed_valid,
    output chn_pkg::seed_item_t seed
);
    import chn_pkg::*;

    logic       front_valid_reg;
    seed_item_t seed_reg;
    seed_item_t seed_next;
    logic       load;

    always_comb
    begin
        seed_next.unit_mode = 1'b0;
        seed_next.seed[0]   = item.coord_a;
        seed_next.seed[1]   = item.coord_a * 32'd3;
        seed_next.seed[2]   = item.coord_a * 32'd131;
        unique case (item.action)
            ACT_ONE:
            begin
                seed_next.seed[0] = item.coord_a;
                seed_next.seed[1] = item.coord_a * 32'd3;
                seed_next.seed[2] = item.coord_a * 32'd131;
            end
            ACT_TWO:
            begin
                seed_next.seed[0] = item.coord_a;
                seed_next.seed[1] = item.coord_b * 32'd3;
                seed_next.seed[2] = item.coord_a * 32'd3 + item.coord_b * 32'd7;
            end
            ACT_THREE:
            begin
                seed_next.seed[0] = item.coord_a;
                seed_next.seed[1] = item.coord_b * 32'd3;
                seed_next.seed[2] = item.coord_c * 32'd131;
            end
            ACT_UNIT:
            begin
                seed_next.unit_mode = 1'b1;
                seed_next.seed[0]   = (item.coord_a + 32'd1) * 32'd217;
                seed_next.seed[1]   = (item.coord_a + 32'd3) * 32'd129;
                seed_next.seed[2]   = (item.coord_a + 32'd5) * 32'd1031;
            end
            default:
            begin
                seed_next.unit_mode = 1'b0;
            end
        endcase
    end

    assign item_stall = front_valid_reg && queue_full;
    assign load       = !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            front_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && item_valid)
        begin
            seed_reg <= seed_next;
        end
    end

    assign seed_valid = front_valid_reg;
    assign seed       = seed_reg;

endmodule

@@ rtl/core/chn_queue.sv @@
// ============================================================================
// chn_queue: seed queue
// Small first-in first-out store between the front and back stages.
// ============================================================================
module chn_queue #(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    input  chn_pkg::seed_item_t wr_data,
    output logic                full,
    input  logic                pop,
    output logic                rd_valid,
    output chn_pkg::seed_item_t rd_data
);
    import chn_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    seed_item_t       store_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             push;

    assign full     = (count_reg == CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && !full;
    assign rd_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd_valid)
        else $error("pop from empty queue");

endmodule

@@ rtl/core/chn_back.sv @@
// ============================================================================
// chn_back: mixing pipeline
// Modulo reduction, weighted round, channel sum and scaled fraction, with
// the result held in an output register.
// ============================================================================
module chn_back #(
    parameter int FRACTION_BITS = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  chn_pkg::seed_item_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_stall,
    output chn_pkg::out_item_t  result
);
    import chn_pkg::*;

    localparam int QW = FRACTION_BITS + 3;
    localparam int EW = (QW > 20) ? QW : 20;
    localparam int PW = QW + 21;
    localparam int XW = FRACTION_BITS + 21;
    localparam int SW = QW + 2;

    // floor(2^(FRACTION_BITS+21) / D); estimate low by at most one
    localparam logic [QW-1:0] FRAC_RECIP [NUM_CH] = '{
        QW'((64'd1 << XW) / 64'(FRAC_DIV[0])),
        QW'((64'd1 << XW) / 64'(FRAC_DIV[1])),
        QW'((64'd1 << XW) / 64'(FRAC_DIV[2]))
    };

    logic                     en;
    logic [5:0]               vld_reg;
    logic [5:0]               unit_reg;
    logic                     result_valid_reg;
    logic                     out_unit_reg;
    out_item_t                result_reg;
    logic [2:0][20:0]         ch6;
    logic [2:0][QW-1:0]       q6;
    logic [21:0]              hash_sum;
    logic [SW-1:0]            qsum;
    logic [23:0]              frac_bits;

    assign en  = !result_valid_reg || !result_stall;
    assign pop = en && head_valid;

    for (genvar g = 0; g < NUM_CH; g++)
    begin : g_ch
        logic [31:0]     s1_seed_reg;
        logic [20:0]     s1_hi_reg;
        logic [11:0]     s1_q_reg;
        logic [43:0]     s1_prod;
        logic [21:0]     s2_t_reg;
        logic [20:0]     s2_hi_reg;
        logic [31:0]     s2_diff;
        logic [20:0]     s3_r_reg;
        logic [20:0]     s3_hi_reg;
        logic [29:0]     wsum;
        logic [20:0]     s4_ch_reg;
        logic [PW-1:0]   s5_prod;
        logic [QW-1:0]   s5_qe_reg;
        logic [20:0]     s5_ch_reg;
        logic [XW-1:0]   xsh;
        logic [EW-1:0]   qe_ext;
        logic [39:0]     qd;
        logic [19:0]     rem;
        logic [QW-1:0]   s6_q_reg;
        logic [20:0]     s6_ch_reg;

        assign s1_prod = 44'(head.seed[g]) * 44'(MOD_RECIP[g]);
        assign s2_diff = s1_seed_reg - 32'(s1_q_reg) * 32'(MODULUS[g]);
        assign wsum    = 30'(s3_r_reg) * 30'(MOD_WEIGHT[g])
                       + 30'(s3_hi_reg) * 30'(AND_WEIGHT[g]);
        assign s5_prod = PW'(s4_ch_reg) * PW'(FRAC_RECIP[g]);
        assign xsh     = XW'(s5_ch_reg) << FRACTION_BITS;
        assign qe_ext  = EW'(s5_qe_reg);
        assign qd      = 40'(qe_ext[19:0]) * 40'(FRAC_DIV[g]);
        assign rem     = xsh[19:0] - qd[19:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s1_seed_reg <= head.seed[g];
                s1_hi_reg   <= 21'(head.seed[g] & 32'(MODULUS[g]));
                s1_q_reg    <= s1_prod[43:32];
                s2_t_reg    <= s2_diff[21:0];
                s2_hi_reg   <= s1_hi_reg;
                s3_r_reg    <= (s2_t_reg >= 22'(MODULUS[g]))
                             ? 21'(s2_t_reg - 22'(MODULUS[g])) : s2_t_reg[20:0];
                s3_hi_reg   <= s2_hi_reg;
                s4_ch_reg   <= 21'(wsum & 30'(RESULT_MASK[g]));
                s5_qe_reg   <= s5_prod[PW-1:21];
                s5_ch_reg   <= s4_ch_reg;
                s6_q_reg    <= s5_qe_reg + QW'(rem >= 20'(FRAC_DIV[g]));
                s6_ch_reg   <= s5_ch_reg;
            end
        end

        assign ch6[g] = s6_ch_reg;
        assign q6[g]  = s6_q_reg;
    end

    assign hash_sum = 22'(ch6[0]) + 22'(ch6[1]) + 22'(ch6[2]);
    assign qsum     = SW'(q6[0]) + SW'(q6[1]) + SW'(q6[2]);

    if (FRACTION_BITS >= 24)
    begin : g_frac_wide
        assign frac_bits = qsum[23:0];
    end
    else
    begin : g_frac_narrow
        assign frac_bits = 24'(qsum[FRACTION_BITS-1:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg          <= {vld_reg[4:0], pop};
            result_valid_reg <= vld_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unit_reg              <= {unit_reg[4:0], head.unit_mode};
            out_unit_reg          <= unit_reg[5];
            result_reg.hash_value <= hash_sum;
            result_reg.fraction   <= unit_reg[5] ? frac_bits : '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_frac_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !out_unit_reg) |-> (result_reg.fraction == '0))
        else $error("fraction set outside unit mode");

    a_hash_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.hash_value <= HASH_MAX))
        else $error("hash value out of range");

    a_pop_gated: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_stall) |-> !pop)
        else $error("queue popped while output stalled");

endmodule

@@ tb/sv/testbench.sv @@
// ============================================================================
// testbench: regression for coordinate_hash_noise
// Drives directed corner items and then random items through the valid/stall
// input channel, predicts each result from the accepted item, and checks the
// output stream in order. Both sides idle at random, and the receiver holds
// off for long stretches so that the block fills up and stalls its input.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import chn_pkg::*;

    localparam int FRACTION_BITS = 24;
    localparam int RANDOM_ITEMS  = 930;
    localparam int MAX_GAP       = 17;

    class hash_scoreboard;
        out_item_t   expected_q[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function word_t mix_lane(word_t s, word_t m, word_t wm, word_t wa, word_t rm);
            return (wm * (s % m) + wa * (s & m)) & rm;
        endfunction

        static function out_item_t predict_hash(in_item_t it);
            word_t       s0;
            word_t       s1;
            word_t       s2;
            word_t       c0;
            word_t       c1;
            word_t       c2;
            word_t       total;
            logic [63:0] scaled;
            out_item_t   r;
            case (it.action)
                ACT_ONE:
                begin
                    s0 = it.coord_a;
                    s1 = 32'd3 * it.coord_a;
                    s2 = 32'd131 * it.coord_a;
                end
                ACT_TWO:
                begin
                    s0 = it.coord_a;
                    s1 = 32'd3 * it.coord_b;
                    s2 = 32'd3 * it.coord_a + 32'd7 * it.coord_b;
                end
                ACT_THREE:
                begin
                    s0 = it.coord_a;
                    s1 = 32'd3 * it.coord_b;
                    s2 = 32'd131 * it.coord_c;
                end
                default:
                begin
                    s0 = (it.coord_a + 32'd1) * 32'd217;
                    s1 = (it.coord_a + 32'd3) * 32'd129;
                    s2 = (it.coord_a + 32'd5) * 32'd1031;
                end
            endcase
            c0 = mix_lane(s0, 32'd1393137, 32'd103, 32'd149, 32'd1395253);
            c1 = mix_lane(s1, 32'd1393148, 32'd161, 32'd123, 32'd1395314);
            c2 = mix_lane(s2, 32'd1393151, 32'd109, 32'd157, 32'd1395329);
            total = c0 + c1 + c2;
            r.hash_value = total[21:0];
            r.fraction = '0;
            if (it.action == ACT_UNIT)
            begin
                scaled = ((64'(c0) << FRACTION_BITS) / 64'd390253)
                       + ((64'(c1) << FRACTION_BITS) / 64'd390299)
                       + ((64'(c2) << FRACTION_BITS) / 64'd390313);
                r.fraction = scaled[23:0];
            end
            return r;
        endfunction

        function void note(in_item_t it);
            expected_q.push_back(predict_hash(it));
        endfunction

        function void check(out_item_t got);
            out_item_t exp;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result hash=%0d fraction=%0h",
                             $realtime, got.hash_value, got.fraction);
                return;
            end
            exp = expected_q.pop_front();
            if (got.hash_value !== exp.hash_value || got.fraction !== exp.fraction)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch: hash exp %0d got %0d, fraction exp %0h got %0h",
                             $realtime, exp.hash_value, got.hash_value,
                             exp.fraction, got.fraction);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    in_item_t   item;
    logic       result_valid;
    logic       result_stall;
    out_item_t  result;

    hash_scoreboard board;
    bit             flood;
    int unsigned    items_sent;

    coordinate_hash_noise #(
        .FRACTION_BITS(FRACTION_BITS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // transfers seen on both channels
    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            board.note(item);
        if (rst_n && result_valid && !result_stall)
            board.check(result);
    end

    function automatic word_t draw_coord();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4, 5:    return word_t'($urandom_range(0, 3000000));
            6, 7:    return 32'hFFFF_FFFF - word_t'($urandom_range(0, 3000000));
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic in_item_t make_item(action_t act, word_t a, word_t b, word_t c);
        in_item_t it;
        it.action  = act;
        it.coord_a = a;
        it.coord_b = b;
        it.coord_c = c;
        return it;
    endfunction

    task automatic send_item(input in_item_t it, input int unsigned gap);
        if (gap != 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(item_valid && !item_stall));
        items_sent++;
    endtask

    function automatic int unsigned sender_gap();
        if (flood || ((items_sent / 70) % 3) == 2)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // receiver: random stalls, quiet stretches and two long hold-offs
    initial
    begin
        int unsigned hold;
        int unsigned taken;
        taken        = 0;
        flood        = 1'b1;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (taken == 0 || taken == 500)
            begin
                hold  = (taken == 0) ? 60 : 80;
                flood = 1'b1;
            end
            else if (((taken / 60) % 3) == 1)
                hold = 0;
            else
                hold = $urandom_range(0, MAX_GAP);
            if (hold != 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                result_stall <= 1'b0;
            end
            flood = 1'b0;
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
            taken++;
        end
    end

    initial
    begin
        #2ms;
        $display("coordinate_hash_noise regression: fail");
        $finish;
    end

    initial
    begin
        in_item_t directed_q[$];
        board        = new();
        items_sent   = 0;
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes per action; unused coordinates carry noise or fixed values
        directed_q.push_back(make_item(ACT_ONE, 32'h0, $urandom(), $urandom()));
        directed_q.push_back(make_item(ACT_ONE, 32'hFFFF_FFFF, $urandom(), $urandom()));
        directed_q.push_back(make_item(ACT_ONE, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_q.push_back(make_item(ACT_ONE, 32'd1393137, 32'h0, 32'h0));
        directed_q.push_back(make_item(ACT_ONE, 32'd1393136, $urandom(), $urandom()));
        directed_q.push_back(make_item(ACT_TWO, 32'h0, 32'h0, $urandom()));
        directed_q.push_back(make_item(ACT_TWO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom()));
        directed_q.push_back(make_item(ACT_TWO, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_q.push_back(make_item(ACT_TWO, 32'h5555_5555, 32'h2492_4925, 32'h0));
        directed_q.push_back(make_item(ACT_THREE, 32'h0, 32'h0, 32'h0));
        directed_q.push_back(make_item(ACT_THREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        directed_q.push_back(make_item(ACT_THREE, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA));
        directed_q.push_back(make_item(ACT_THREE, 32'd1393137, 32'd1393148, 32'd1393151));
        directed_q.push_back(make_item(ACT_UNIT, 32'h0, $urandom(), $urandom()));
        directed_q.push_back(make_item(ACT_UNIT, 32'hFFFF_FFFF, $urandom(), $urandom()));
        directed_q.push_back(make_item(ACT_UNIT, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0));
        directed_q.push_back(make_item(ACT_UNIT, 32'hFFFF_FFFC, 32'h0, 32'hFFFF_FFFF));
        directed_q.push_back(make_item(ACT_UNIT, 32'hFFFF_FFFA, $urandom(), $urandom()));
        directed_q.push_back(make_item(ACT_UNIT, 32'h8000_0000, $urandom(), $urandom()));
        directed_q.push_back(make_item(ACT_UNIT, 32'h7FFF_FFFF, $urandom(), $urandom()));
        foreach (directed_q[i])
            send_item(directed_q[i], sender_gap());

        repeat (RANDOM_ITEMS)
            send_item(make_item(action_t'($urandom_range(0, 3)), draw_coord(),
                                draw_coord(), draw_coord()), sender_gap());
        item_valid <= 1'b0;

        while (board.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("coordinate_hash_noise regression: pass");
        else
            $display("coordinate_hash_noise regression: fail");
        $finish;
    end
endmodule
